// File: design/mct_pkg.sv
// shared types and constants for the match compare timer block
// no dependencies
`default_nettype none

package mct_pkg;

  localparam int IDX_W  = 10;
  localparam int WORD_W = 32;
  localparam int IRQ_W  = 3;

  localparam logic [IDX_W-1:0] IDX_GLOBAL = 10'd0;
  localparam logic [IDX_W-1:0] IDX_COUNT  = 10'd1;
  localparam int IDX_CHAN_BASE = 2;
  localparam int CHAN_STRIDE   = 3;
  localparam int SLOT_MATCH    = 0;
  localparam int SLOT_INTERVAL = 1;
  localparam int SLOT_CTRL     = 2;

  localparam int GLOBAL_ENABLE_BIT = 0;
  localparam int CTRL_IRQ_EN_BIT   = 0;
  localparam int CTRL_PERIODIC_BIT = 1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } mct_op_t;

  typedef struct packed {
    logic             tick_en;
    logic             wr_en;
    logic [IDX_W-1:0] word_index;
  } mct_cmd_t;

endpackage

`default_nettype wire

// File: design/match_compare_timer_block_core.sv
// match compare timer block top level: request register, counter, result register
// depends on mct_pkg and mct_chan
`default_nettype none

// usage
//   input channel in_valid / in_stall carries one request: a counter tick,
//   a register read or a register write at a word index of the register page
//   result channel out_valid / out_stall returns one result per request:
//   read data for reads, fired interrupt bits for ticks, zero otherwise
//   a request waits in the request register, its result in the result register
//   throughput: one request per cycle while out_stall is low; the request
//   and result registers let a new request enter while a finished result waits
//   the counter, channel registers and all results are updated in the single
//   pass from the request register to the result register, so every request
//   sees the state left by the one before it
//   out_stall holds the result register; in_stall rises only when a request
//   is waiting and the result register cannot move
//   synchronous reset clears counter, enable and all channel registers,
//   and empties both registers

module match_compare_timer_block_core #(
  parameter int NUM_CHANNELS = 3,
  parameter int COUNT_BITS   = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_op,
  input  wire logic [mct_pkg::IDX_W-1:0]   in_word_index,
  input  wire logic [mct_pkg::WORD_W-1:0]  in_write_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [mct_pkg::WORD_W-1:0]  out_read_data,
  output logic      [mct_pkg::IRQ_W-1:0]   out_irq_fired
);
  import mct_pkg::*;

  localparam int CMP_W = (COUNT_BITS > WORD_W) ? COUNT_BITS : WORD_W;

  logic              req_valid_r;
  logic [1:0]        req_op_r;
  logic [IDX_W-1:0]  req_idx_r;
  logic [WORD_W-1:0] req_data_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] read_data_r, read_data_nxt;
  logic [IRQ_W-1:0]  irq_r, irq_nxt;

  logic [COUNT_BITS-1:0] count_r, count_nxt, count_inc, count_wr;
  logic                  enable_r, enable_nxt;
  logic [CMP_W-1:0]      count_cmp, data_ext, count_ext;

  logic     advance, is_tick, is_read, is_write;
  mct_cmd_t cmd;

  logic [WORD_W-1:0]       chan_rd [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] chan_irq;
  logic [WORD_W-1:0]       chan_rd_or;

  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;

  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (req_op_r)
      OP_TICK:  is_tick  = 1'b1;
      OP_READ:  is_read  = 1'b1;
      OP_WRITE: is_write = 1'b1;
      default: ;
    endcase
  end

  assign cmd.tick_en    = advance && is_tick && enable_r;
  assign cmd.wr_en      = advance && is_write;
  assign cmd.word_index = req_idx_r;

  assign count_inc = count_r + 1'b1;
  assign data_ext  = CMP_W'(req_data_r);
  assign count_wr  = data_ext[COUNT_BITS-1:0];
  assign count_ext = CMP_W'(count_r);
  assign count_cmp = CMP_W'(count_inc);

  always_comb begin
    count_nxt  = count_r;
    enable_nxt = enable_r;
    if (cmd.tick_en) begin
      count_nxt = count_inc;
    end
    if (cmd.wr_en && req_idx_r == IDX_GLOBAL) begin
      enable_nxt = req_data_r[GLOBAL_ENABLE_BIT];
    end
    if (cmd.wr_en && req_idx_r == IDX_COUNT) begin
      count_nxt = count_wr;
    end
  end

  for (genvar n = 0; n < NUM_CHANNELS; n++) begin : g_chan
    mct_chan #(
      .CH    (n),
      .CMP_W (CMP_W)
    ) u_chan (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .write_data (req_data_r),
      .count_nxt  (count_cmp),
      .read_data  (chan_rd[n]),
      .irq        (chan_irq[n])
    );
  end

  always_comb begin
    chan_rd_or = '0;
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      chan_rd_or = chan_rd_or | chan_rd[n];
    end
  end

  for (genvar i = 0; i < IRQ_W; i++) begin : g_irq
    if (i < NUM_CHANNELS) begin : g_used
      assign irq_nxt[i] = chan_irq[i];
    end else begin : g_unused
      assign irq_nxt[i] = 1'b0;
    end
  end

  always_comb begin
    read_data_nxt = '0;
    if (is_read) begin
      if (req_idx_r == IDX_GLOBAL) begin
        read_data_nxt[GLOBAL_ENABLE_BIT] = enable_r;
      end else if (req_idx_r == IDX_COUNT) begin
        read_data_nxt = count_ext[WORD_W-1:0];
      end else begin
        read_data_nxt = chan_rd_or;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      enable_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      enable_r <= enable_nxt;
      if (in_valid && !in_stall) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op_r   <= in_op;
      req_idx_r  <= in_word_index;
      req_data_r <= in_write_data;
    end
    if (advance) begin
      read_data_r <= read_data_nxt;
      irq_r       <= irq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = read_data_r;
  assign out_irq_fired = irq_r;

endmodule

`default_nettype wire

// File: design/mct_chan.sv
// one match channel: match, interval and control registers, compare and rearm
// depends on mct_pkg
`default_nettype none

module mct_chan #(
  parameter int CH    = 0,
  parameter int CMP_W = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mct_pkg::mct_cmd_t           cmd,
  input  wire logic [mct_pkg::WORD_W-1:0]  write_data,
  input  wire logic [CMP_W-1:0]            count_nxt,
  output logic      [mct_pkg::WORD_W-1:0]  read_data,
  output logic                             irq
);
  import mct_pkg::*;

  localparam int BASE = IDX_CHAN_BASE + CHAN_STRIDE * CH;
  localparam logic [IDX_W-1:0] MATCH_IDX    = IDX_W'(BASE + SLOT_MATCH);
  localparam logic [IDX_W-1:0] INTERVAL_IDX = IDX_W'(BASE + SLOT_INTERVAL);
  localparam logic [IDX_W-1:0] CTRL_IDX     = IDX_W'(BASE + SLOT_CTRL);

  logic [WORD_W-1:0] match_r, match_nxt;
  logic [WORD_W-1:0] interval_r, interval_nxt;
  logic              irq_en_r, irq_en_nxt;
  logic              periodic_r, periodic_nxt;
  logic              hit;

  assign hit = cmd.tick_en && (CMP_W'(match_r) == count_nxt);
  assign irq = hit && irq_en_r;

  always_comb begin
    match_nxt    = match_r;
    interval_nxt = interval_r;
    irq_en_nxt   = irq_en_r;
    periodic_nxt = periodic_r;
    if (hit && periodic_r) begin
      match_nxt = match_r + interval_r;
    end
    if (cmd.wr_en) begin
      if (cmd.word_index == MATCH_IDX) begin
        match_nxt = write_data;
      end
      if (cmd.word_index == INTERVAL_IDX) begin
        interval_nxt = write_data;
      end
      if (cmd.word_index == CTRL_IDX) begin
        irq_en_nxt   = write_data[CTRL_IRQ_EN_BIT];
        periodic_nxt = write_data[CTRL_PERIODIC_BIT];
      end
    end
  end

  always_comb begin
    read_data = '0;
    if (cmd.word_index == MATCH_IDX) begin
      read_data = match_r;
    end else if (cmd.word_index == INTERVAL_IDX) begin
      read_data = interval_r;
    end else if (cmd.word_index == CTRL_IDX) begin
      read_data[CTRL_IRQ_EN_BIT]   = irq_en_r;
      read_data[CTRL_PERIODIC_BIT] = periodic_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= '0;
      interval_r <= '0;
      irq_en_r   <= 1'b0;
      periodic_r <= 1'b0;
    end else begin
      match_r    <= match_nxt;
      interval_r <= interval_nxt;
      irq_en_r   <= irq_en_nxt;
      periodic_r <= periodic_nxt;
    end
  end

endmodule

`default_nettype wire
